FILE: hw/rtl/mrr_pkg.sv
package mrr_pkg;

    // Field and internal widths
    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int PER_W   = 11;
    localparam int ROT_W   = 32;
    localparam int VAL_W   = 32;

    // Largest matrix side that the dimensions are saturated to
    localparam int MAX_DIM = 256;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_COUNT = 2'd2;

    // Remainder unit: bits of the rotation count retired per stage
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = ROT_W / DIV_STEP;

    // Stage positions in the pipe
    localparam int ST_RING = 0;
    localparam int ST_GEOM = 1;
    localparam int ST_DIV0 = 2;
    localparam int ST_WRAP = ST_DIV0 + DIV_STAGES;
    localparam int NSTAGE  = ST_WRAP + 1;

    // One item as it travels down the pipe
    typedef struct packed {
        logic [COORD_W-1:0]      src_row;
        logic [COORD_W-1:0]      src_col;
        logic signed [VAL_W-1:0] value;
        logic                    remap;
        logic [DIM_W-1:0]        ring;
        logic [DIM_W-1:0]        m1;
        logic [DIM_W-1:0]        n1;
        logic [PER_W-1:0]        per;
        logic [PER_W-1:0]        pos;
        logic [PER_W-1:0]        rem;
    } t_item;

    // Shift DIV_STEP dividend bits into a partial remainder, reducing each time
    function automatic logic [PER_W-1:0] mod_step(
        input logic [PER_W-1:0]    rem,
        input logic [DIV_STEP-1:0] bits,
        input logic [PER_W-1:0]    per
    );
        logic [PER_W:0] acc;
        acc = {1'b0, rem};
        for (int i = DIV_STEP - 1; i >= 0; i--) begin
            acc = {acc[PER_W-1:0], bits[i]};
            if (acc >= {1'b0, per}) begin
                acc = acc - {1'b0, per};
            end
        end
        return acc[PER_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/matrix_ring_rotation_remap_unit.sv
// Matrix ring rotation remap.
// Input channel (i_in_valid / o_in_ready) takes one matrix element per item:
// its row, column and value. Output channel (o_out_valid / i_out_ready) gives
// the row and column where the element lands once every concentric ring is
// rotated counterclockwise by the rotation count, with the value unchanged.
// Elements outside the matrix or in the central strip keep their place.
// Configuration is a plain write port (row count, column count, rotation
// count). The user must see that it is written only while no item is in
// flight; the block does not enforce this. Throughput: one item per cycle
// while the receiver does not stall. The remainder unit (rotation count mod
// perimeter) retires four dividend bits per stage over eight stages, after
// the ring and geometry stages and before the wrap and output stages.
// Reset clears all valid bits and loads row_count = 2, col_count = 2,
// rotation_count = 0.
// When the receiver stalls, the whole pipe holds and o_in_ready drops; no
// item is lost or repeated.
module matrix_ring_rotation_remap_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mrr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mrr_pkg::ROT_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mrr_pkg::COORD_W-1:0]          i_src_row,
    input  logic [mrr_pkg::COORD_W-1:0]          i_src_col,
    input  logic signed [mrr_pkg::VAL_W-1:0]     i_elem_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mrr_pkg::COORD_W-1:0]          o_dest_row,
    output logic [mrr_pkg::COORD_W-1:0]          o_dest_col,
    output logic signed [mrr_pkg::VAL_W-1:0]     o_out_value
);

    localparam int DIM_W   = mrr_pkg::DIM_W;
    localparam int PER_W   = mrr_pkg::PER_W;
    localparam int COORD_W = mrr_pkg::COORD_W;
    localparam logic [DIM_W-1:0] DIM_HI = DIM_W'(mrr_pkg::MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_LO = DIM_W'(2);

    // Configuration registers
    logic [DIM_W-1:0]         r_row_count;
    logic [DIM_W-1:0]         r_col_count;
    logic [mrr_pkg::ROT_W-1:0] r_rotation_count;

    // Pipe
    mrr_pkg::t_item r_pipe [mrr_pkg::NSTAGE];
    mrr_pkg::t_item n_pipe [mrr_pkg::NSTAGE];
    logic [mrr_pkg::NSTAGE-1:0] r_vld;

    // Output register
    logic                            r_out_vld;
    logic [COORD_W-1:0]              r_dest_row;
    logic [COORD_W-1:0]              r_dest_col;
    logic signed [mrr_pkg::VAL_W-1:0] r_out_value;
    logic [COORD_W-1:0]              n_dest_row;
    logic [COORD_W-1:0]              n_dest_col;

    logic             en;
    logic [DIM_W-1:0] rows_c;
    logic [DIM_W-1:0] cols_c;

    // Stage-local values
    logic [DIM_W-1:0] s0_r, s0_c, s0_dbot, s0_dright, s0_min_a, s0_min_b;
    logic [DIM_W-1:0] s0_ring, s0_lim;
    logic             s0_in_mat;
    logic [DIM_W-1:0] s1_m1, s1_n1, s1_r, s1_c;
    logic [PER_W-1:0] s1_r11, s1_c11, s1_ring11, s1_m1_11, s1_n1_11;
    logic [PER_W:0]   sw_sum;
    logic [PER_W-1:0] so_j, so_ring, so_m1, so_n1, so_dr, so_dc;

    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_vld;
    assign o_dest_row  = r_dest_row;
    assign o_dest_col  = r_dest_col;
    assign o_out_value = r_out_value;

    // Saturate dimensions into the legal range
    always_comb begin
        if (r_row_count < DIM_LO) begin
            rows_c = DIM_LO;
        end else if (r_row_count > DIM_HI) begin
            rows_c = DIM_HI;
        end else begin
            rows_c = r_row_count;
        end
        if (r_col_count < DIM_LO) begin
            cols_c = DIM_LO;
        end else if (r_col_count > DIM_HI) begin
            cols_c = DIM_HI;
        end else begin
            cols_c = r_col_count;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count      <= DIM_W'(2);
            r_col_count      <= DIM_W'(2);
            r_rotation_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mrr_pkg::CFG_ROW_COUNT:      r_row_count      <= i_cfg_data[DIM_W-1:0];
                mrr_pkg::CFG_COL_COUNT:      r_col_count      <= i_cfg_data[DIM_W-1:0];
                mrr_pkg::CFG_ROTATION_COUNT: r_rotation_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ring stage: distance to the nearest edge
    always_comb begin
        s0_r      = DIM_W'(i_src_row);
        s0_c      = DIM_W'(i_src_col);
        s0_in_mat = (s0_r < rows_c) && (s0_c < cols_c);
        s0_dbot   = rows_c - DIM_W'(1) - s0_r;
        s0_dright = cols_c - DIM_W'(1) - s0_c;
        s0_min_a  = (s0_r < s0_c) ? s0_r : s0_c;
        s0_min_b  = (s0_dbot < s0_dright) ? s0_dbot : s0_dright;
        s0_ring   = (s0_min_a < s0_min_b) ? s0_min_a : s0_min_b;
        s0_lim    = ((rows_c < cols_c) ? rows_c : cols_c) >> 1;

        n_pipe[mrr_pkg::ST_RING]         = '0;
        n_pipe[mrr_pkg::ST_RING].src_row = i_src_row;
        n_pipe[mrr_pkg::ST_RING].src_col = i_src_col;
        n_pipe[mrr_pkg::ST_RING].value   = i_elem_value;
        n_pipe[mrr_pkg::ST_RING].remap   = s0_in_mat && (s0_ring < s0_lim);
        n_pipe[mrr_pkg::ST_RING].ring    = s0_ring;
    end

    // Geometry stage: ring size, perimeter and position on the walk
    always_comb begin
        n_pipe[mrr_pkg::ST_GEOM] = r_pipe[mrr_pkg::ST_RING];
        s1_m1 = rows_c - {r_pipe[mrr_pkg::ST_RING].ring[DIM_W-2:0], 1'b0} - DIM_W'(1);
        s1_n1 = cols_c - {r_pipe[mrr_pkg::ST_RING].ring[DIM_W-2:0], 1'b0} - DIM_W'(1);
        s1_r  = DIM_W'(r_pipe[mrr_pkg::ST_RING].src_row);
        s1_c  = DIM_W'(r_pipe[mrr_pkg::ST_RING].src_col);
        s1_r11    = PER_W'(s1_r);
        s1_c11    = PER_W'(s1_c);
        s1_ring11 = PER_W'(r_pipe[mrr_pkg::ST_RING].ring);
        s1_m1_11  = PER_W'(s1_m1);
        s1_n1_11  = PER_W'(s1_n1);

        n_pipe[mrr_pkg::ST_GEOM].m1  = s1_m1;
        n_pipe[mrr_pkg::ST_GEOM].n1  = s1_n1;
        n_pipe[mrr_pkg::ST_GEOM].per = (s1_m1_11 + s1_n1_11) << 1;
        n_pipe[mrr_pkg::ST_GEOM].rem = '0;
        priority if (s1_c == r_pipe[mrr_pkg::ST_RING].ring) begin
            n_pipe[mrr_pkg::ST_GEOM].pos = s1_r11 - s1_ring11;
        end else if (s1_r11 == s1_ring11 + s1_m1_11) begin
            n_pipe[mrr_pkg::ST_GEOM].pos = s1_m1_11 + (s1_c11 - s1_ring11);
        end else if (s1_c11 == s1_ring11 + s1_n1_11) begin
            n_pipe[mrr_pkg::ST_GEOM].pos = s1_m1_11 + s1_n1_11
                                         + (s1_ring11 + s1_m1_11 - s1_r11);
        end else begin
            n_pipe[mrr_pkg::ST_GEOM].pos = (s1_m1_11 << 1) + s1_n1_11
                                         + (s1_ring11 + s1_n1_11 - s1_c11);
        end
    end

    // Remainder stages: rotation count mod perimeter, high bits first
    for (genvar k = 0; k < mrr_pkg::DIV_STAGES; k++) begin : g_div
        always_comb begin
            n_pipe[mrr_pkg::ST_DIV0 + k]     = r_pipe[mrr_pkg::ST_DIV0 + k - 1];
            n_pipe[mrr_pkg::ST_DIV0 + k].rem = mrr_pkg::mod_step(
                r_pipe[mrr_pkg::ST_DIV0 + k - 1].rem,
                r_rotation_count[mrr_pkg::ROT_W - 1 - mrr_pkg::DIV_STEP * k
                                 -: mrr_pkg::DIV_STEP],
                r_pipe[mrr_pkg::ST_DIV0 + k - 1].per);
        end
    end

    // Wrap stage: advance position and fold back under the perimeter
    always_comb begin
        n_pipe[mrr_pkg::ST_WRAP] = r_pipe[mrr_pkg::ST_WRAP - 1];
        sw_sum = {1'b0, r_pipe[mrr_pkg::ST_WRAP - 1].pos}
               + {1'b0, r_pipe[mrr_pkg::ST_WRAP - 1].rem};
        if (sw_sum >= {1'b0, r_pipe[mrr_pkg::ST_WRAP - 1].per}) begin
            sw_sum = sw_sum - {1'b0, r_pipe[mrr_pkg::ST_WRAP - 1].per};
        end
        n_pipe[mrr_pkg::ST_WRAP].pos = sw_sum[PER_W-1:0];
    end

    // Output stage: walk position back to row and column
    always_comb begin
        so_j    = r_pipe[mrr_pkg::ST_WRAP].pos;
        so_ring = PER_W'(r_pipe[mrr_pkg::ST_WRAP].ring);
        so_m1   = PER_W'(r_pipe[mrr_pkg::ST_WRAP].m1);
        so_n1   = PER_W'(r_pipe[mrr_pkg::ST_WRAP].n1);
        priority if (so_j < so_m1) begin
            so_dr = so_ring + so_j;
            so_dc = so_ring;
        end else if (so_j < so_m1 + so_n1) begin
            so_dr = so_ring + so_m1;
            so_dc = so_ring + (so_j - so_m1);
        end else if (so_j < (so_m1 << 1) + so_n1) begin
            so_dr = so_ring + so_m1 - (so_j - so_m1 - so_n1);
            so_dc = so_ring + so_n1;
        end else begin
            so_dr = so_ring;
            so_dc = so_ring + so_n1 - (so_j - (so_m1 << 1) - so_n1);
        end
        if (r_pipe[mrr_pkg::ST_WRAP].remap) begin
            n_dest_row = so_dr[COORD_W-1:0];
            n_dest_col = so_dc[COORD_W-1:0];
        end else begin
            n_dest_row = r_pipe[mrr_pkg::ST_WRAP].src_row;
            n_dest_col = r_pipe[mrr_pkg::ST_WRAP].src_col;
        end
    end

    // Valid bits: advance together, hold on stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[mrr_pkg::NSTAGE-2:0], i_in_valid};
            r_out_vld <= r_vld[mrr_pkg::NSTAGE-1];
        end
    end

    // Payload: advance with the valid bits
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < mrr_pkg::NSTAGE; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
            r_dest_row  <= n_dest_row;
            r_dest_col  <= n_dest_col;
            r_out_value <= r_pipe[mrr_pkg::ST_WRAP].value;
        end
    end

endmodule
